/* src/fsp_pkg.sv */
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared constants, opcode and command codes, stage latch types and
// controller/datapath handshake structs for the five-stage pipeline block.
// ----------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

  // storage sizes
  localparam int REG_COUNT  = 32;
  localparam int DATA_DEPTH = 1024;
  localparam int PROG_DEPTH = 256;

  localparam int RADDR_W = $clog2(REG_COUNT);
  localparam int DADDR_W = $clog2(DATA_DEPTH);
  localparam int PADDR_W = $clog2(PROG_DEPTH);
  localparam int PC_W    = (PADDR_W + 1 > 9) ? PADDR_W + 1 : 9;

  // fixed field widths
  localparam int PLEN_W    = 9;
  localparam int ST_ADDR_W = 10;
  localparam int IN_W      = 112;
  localparam int OUT_W     = 152;

  // input tdata layout, lowest bit first
  localparam int IN_CMD_LO  = 0;
  localparam int IN_SLOT_LO = 2;
  localparam int IN_OP_LO   = 12;
  localparam int IN_RD_LO   = 17;
  localparam int IN_RS1_LO  = 23;
  localparam int IN_RS2_LO  = 29;
  localparam int IN_IMM_LO  = 35;
  localparam int IN_TGT_LO  = 67;
  localparam int IN_DATA_LO = 75;

  localparam logic [5:0] REG_NONE = 6'h3F;

  typedef enum logic [1:0] {
    CMD_INSTR = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_ADDI = 5'd2,
    OP_SUBI = 5'd3,
    OP_LW   = 5'd4,
    OP_SW   = 5'd5,
    OP_BEQ  = 5'd6,
    OP_BNE  = 5'd7,
    OP_BGT  = 5'd8,
    OP_BLT  = 5'd9,
    OP_J    = 5'd10,
    OP_LI   = 5'd11,
    OP_MOV  = 5'd12,
    OP_MUL  = 5'd13,
    OP_DIV  = 5'd14,
    OP_HALT = 5'd15,
    OP_NOP  = 5'd16
  } op_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_MEM,
    ST_RD,
    ST_EX,
    ST_DIV,
    ST_DEC,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [4:0]  op;
    logic [5:0]  rd;
    logic [5:0]  rs1;
    logic [5:0]  rs2;
    logic [31:0] imm;
    logic [7:0]  tgt;
  } instr_t;

  typedef struct packed {
    instr_t      ins;
    logic [5:0]  dest;
    logic        wr;
    logic        mrd;
    logic        mwr;
    logic        taken;
    logic [31:0] res;
    logic [31:0] sdata;
    logic [31:0] wbv;
  } stage_t;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic accept;
    logic mem;
    logic rd;
    logic ex;
    logic div_end;
    logic dec;
    logic fetch;
    logic out_load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic ex_div;
    logic div_done;
  } ctl_sts_t;

  // register number names a real register
  function automatic logic reg_ok(input logic [5:0] r);
    return !r[5] && (32'(r) < 32'(REG_COUNT));
  endfunction

endpackage

`default_nettype wire

/* src/five_stage_pipeline_with_forwarding_unit.sv */
// ----------------------------------------------------------------------------
// five_stage_pipeline_with_forwarding_unit
// Command-driven five-stage pipeline model with forwarding, load-use stall
// and branch flush; one status result per command.
// ----------------------------------------------------------------------------
//  channel  ports              width  contents
//  in       in_t*              112    command, load payload or tick
//  out      out_t*             152    write-back, store, flags, counters
//  cfg      cfg_we/cfg_wdata   9      program length
//
//  A tick runs the mem, read, execute, decode, fetch and done phases, with
//  a divide phase after execute when it holds a DIV (the divider retires
//  one quotient bit per cycle). Load commands go from acceptance straight
//  to the done phase. After reset the data memory is cleared one word per
//  cycle with in_tready low.
//  A result waiting on out_tready holds the next item in the done phase.
// ----------------------------------------------------------------------------
`default_nettype none

module five_stage_pipeline_with_forwarding_unit
  import fsp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  // command[1:0] slot_address[11:2] opcode[16:12] dest_reg[22:17]
  // src_reg_a[28:23] src_reg_b[34:29] immediate_or_offset[66:35]
  // branch_target[74:67] data_word[106:75], zero fill above
  input  wire logic [IN_W-1:0]    in_tdata,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // writeback_valid[0] writeback_reg[5:1] writeback_value[37:6]
  // store_valid[38] store_address[48:39] store_value[80:49] stalled[81]
  // flushed[82] halted[83] drained[84] cycle_count[116:85]
  // retired_count[148:117], zero fill above
  output logic [OUT_W-1:0]        out_tdata,
  input  wire logic               cfg_we,
  input  wire logic [PLEN_W-1:0]  cfg_wdata
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  cmd_t     in_cmd;

  assign in_cmd = cmd_t'(in_tdata[IN_CMD_LO +: 2]);

  fsp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  fsp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

/* src/fsp_div.sv */
// ----------------------------------------------------------------------------
// fsp_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero; a zero divisor gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_div
  import fsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dvd,
  input  wire logic [31:0] dvs,
  output logic             done,
  output logic [31:0]      quo
);

  logic [4:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [32:0] rem_r;
  logic [31:0] q_r;
  logic [31:0] ub_r;
  logic        neg_r;
  logic        zero_r;

  logic [32:0] rem_sh;
  logic        fits;

  // one restoring step
  always_comb begin
    rem_sh = {rem_r[31:0], q_r[31]};
    fits   = rem_sh >= {1'b0, ub_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= dvd[31] ? (32'd0 - dvd) : dvd;
      ub_r   <= dvs[31] ? (32'd0 - dvs) : dvs;
      neg_r  <= dvd[31] ^ dvs[31];
      zero_r <= (dvs == 32'd0);
      rem_r  <= '0;
    end else if (run_r) begin
      rem_r <= fits ? (rem_sh - {1'b0, ub_r}) : rem_sh;
      q_r   <= {q_r[30:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = zero_r ? 32'd0 : (neg_r ? (32'd0 - q_r) : q_r);

endmodule

`default_nettype wire

/* src/fsp_datapath.sv */
// ----------------------------------------------------------------------------
// fsp_datapath
// Stage latches, register file, instruction and data memories, ALU with
// forwarding, divider and the result register of the pipeline block.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_datapath
  import fsp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctl_cmd_t           cmd,
  output ctl_sts_t                sts,
  input  wire logic [IN_W-1:0]    in_tdata,
  input  wire logic               cfg_we,
  input  wire logic [PLEN_W-1:0]  cfg_wdata,
  output logic [OUT_W-1:0]        out_tdata
);

  // input fields
  logic [1:0]  f_cmd;
  logic [9:0]  f_slot;
  instr_t      f_ins;
  logic [31:0] f_data;

  assign f_cmd      = in_tdata[IN_CMD_LO +: 2];
  assign f_slot     = in_tdata[IN_SLOT_LO +: 10];
  assign f_ins.op   = in_tdata[IN_OP_LO +: 5];
  assign f_ins.rd   = in_tdata[IN_RD_LO +: 6];
  assign f_ins.rs1  = in_tdata[IN_RS1_LO +: 6];
  assign f_ins.rs2  = in_tdata[IN_RS2_LO +: 6];
  assign f_ins.imm  = in_tdata[IN_IMM_LO +: 32];
  assign f_ins.tgt  = in_tdata[IN_TGT_LO +: 8];
  assign f_data     = in_tdata[IN_DATA_LO +: 32];

  // memories
  instr_t      imem [PROG_DEPTH];
  instr_t      imem_q_r;
  logic [31:0] dmem [DATA_DEPTH];
  logic [31:0] dmem_q_r;
  logic [31:0] rf [REG_COUNT];
  logic [31:0] rfa_q_r;
  logic [31:0] rfb_q_r;

  // pipeline and control state
  logic [REG_COUNT-1:0] rf_v_r;
  logic                 rfa_v_r;
  logic                 rfb_v_r;
  stage_t               fd_r, de_r, em_r, mw_r;
  logic                 fd_v_r, de_v_r, em_v_r, mw_v_r;
  logic [PC_W-1:0]      pc_r;
  logic                 halt_r;
  logic [PLEN_W-1:0]    plen_r;
  logic [31:0]          tick_r;
  logic [31:0]          ret_r;
  logic                 hz_r;
  logic                 ld_pend_r;
  logic                 fetch_pend_r;
  logic [DADDR_W-1:0]   clr_addr_r;

  // per-item result
  logic                 r_wbv_r;
  logic [4:0]           r_wbreg_r;
  logic [31:0]          r_wbval_r;
  logic                 r_stv_r;
  logic [ST_ADDR_W-1:0] r_staddr_r;
  logic [31:0]          r_stval_r;
  logic                 r_stall_r;
  logic                 r_flush_r;
  logic [OUT_W-1:0]     out_tdata_r;

  // memory port control
  logic               dm_we;
  logic [DADDR_W-1:0] dm_wa;
  logic [31:0]        dm_wd;
  logic               em_inrange;
  logic               mw_wr_ok;
  logic               rf_we;
  logic [5:0]         rd_b_reg;
  logic               im_we;

  assign em_inrange = em_r.res < 32'(DATA_DEPTH);
  assign mw_wr_ok   = mw_v_r && mw_r.wr && !mw_r.dest[5] && (mw_r.dest != 6'd0);
  assign rf_we      = cmd.mem && mw_wr_ok;
  assign im_we      = cmd.accept && (f_cmd == CMD_INSTR) && (32'(f_slot) < 32'(PROG_DEPTH));
  assign rd_b_reg   = (de_r.ins.op == OP_SW) ? de_r.ins.rd : de_r.ins.rs2;

  // data memory write source
  always_comb begin
    dm_we = 1'b0;
    dm_wa = clr_addr_r;
    dm_wd = 32'd0;
    if (cmd.clr) begin
      dm_we = 1'b1;
    end else if (cmd.accept && (f_cmd == CMD_DATA) && (32'(f_slot) < 32'(DATA_DEPTH))) begin
      dm_we = 1'b1;
      dm_wa = f_slot[DADDR_W-1:0];
      dm_wd = f_data;
    end else if (cmd.mem && em_v_r && em_r.mwr && em_inrange) begin
      dm_we = 1'b1;
      dm_wa = em_r.res[DADDR_W-1:0];
      dm_wd = em_r.sdata;
    end
  end

  // data memory
  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[dm_wa] <= dm_wd;
    end
    dmem_q_r <= dmem[em_r.res[DADDR_W-1:0]];
  end

  // instruction memory
  always_ff @(posedge clk) begin
    if (im_we) begin
      imem[f_slot[PADDR_W-1:0]] <= f_ins;
    end
    if (cmd.dec) begin
      imem_q_r <= imem[pc_r[PADDR_W-1:0]];
    end
  end

  // register file, two read ports
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[mw_r.dest[RADDR_W-1:0]] <= mw_r.wbv;
    end
    if (cmd.rd) begin
      rfa_q_r <= rf[de_r.ins.rs1[RADDR_W-1:0]];
      rfb_q_r <= rf[rd_b_reg[RADDR_W-1:0]];
    end
  end

  // operands with forwarding from the memory/write-back latch
  logic [31:0] opa, opb;
  logic [5:0]  rb;

  always_comb begin
    rb = rd_b_reg;
    if (!reg_ok(de_r.ins.rs1) || de_r.ins.rs1 == 6'd0) begin
      opa = 32'd0;
    end else if (mw_v_r && mw_r.wr && mw_r.dest == de_r.ins.rs1) begin
      opa = mw_r.wbv;
    end else begin
      opa = rfa_v_r ? rfa_q_r : 32'd0;
    end
    if (!reg_ok(rb) || rb == 6'd0) begin
      opb = 32'd0;
    end else if (mw_v_r && mw_r.wr && mw_r.dest == rb) begin
      opb = mw_r.wbv;
    end else begin
      opb = rfb_v_r ? rfb_q_r : 32'd0;
    end
  end

  // alu
  stage_t      em_nxt;
  logic [31:0] mul_lo;

  assign mul_lo = opa * opb;

  always_comb begin
    em_nxt       = de_r;
    em_nxt.res   = 32'd0;
    em_nxt.taken = 1'b0;
    case (de_r.ins.op)
      OP_ADD:  em_nxt.res = opa + opb;
      OP_SUB:  em_nxt.res = opa - opb;
      OP_ADDI: em_nxt.res = opa + de_r.ins.imm;
      OP_SUBI: em_nxt.res = opa - de_r.ins.imm;
      OP_LW:   em_nxt.res = opa + de_r.ins.imm;
      OP_SW: begin
        em_nxt.res   = opa + de_r.ins.imm;
        em_nxt.sdata = opb;
      end
      OP_BEQ:  em_nxt.taken = (opa == opb);
      OP_BNE:  em_nxt.taken = (opa != opb);
      OP_BGT:  em_nxt.taken = ($signed(opb) < $signed(opa));
      OP_BLT:  em_nxt.taken = ($signed(opa) < $signed(opb));
      OP_J:    em_nxt.taken = 1'b1;
      OP_LI:   em_nxt.res = de_r.ins.imm;
      OP_MOV:  em_nxt.res = opa;
      OP_MUL:  em_nxt.res = mul_lo;
      default: em_nxt.res = 32'd0;
    endcase
  end

  // divider
  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;

  assign div_start = cmd.ex && de_v_r && (de_r.ins.op == OP_DIV);

  fsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (opa),
    .dvs   (opb),
    .done  (div_done),
    .quo   (div_q)
  );

  // decode of the fetch/decode latch
  stage_t de_nxt;
  logic   dec_wr;

  always_comb begin
    dec_wr        = (fd_r.ins.op inside {[OP_ADD:OP_LW], [OP_LI:OP_DIV]});
    de_nxt        = '0;
    de_nxt.ins    = fd_r.ins;
    de_nxt.mrd    = (fd_r.ins.op == OP_LW);
    de_nxt.mwr    = (fd_r.ins.op == OP_SW);
    de_nxt.wr     = dec_wr;
    de_nxt.dest   = (dec_wr && reg_ok(fd_r.ins.rd)) ? fd_r.ins.rd : REG_NONE;
  end

  // fetch limit
  logic [31:0] len32;
  logic        fetch_ok;

  assign len32    = (32'(plen_r) < 32'(PROG_DEPTH)) ? 32'(plen_r) : 32'(PROG_DEPTH);
  assign fetch_ok = !hz_r && !halt_r;

  logic drained;
  assign drained = halt_r && !fd_v_r && !de_v_r && !em_v_r && !mw_v_r;

  // pipeline sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_v_r       <= '0;
      fd_v_r       <= 1'b0;
      de_v_r       <= 1'b0;
      em_v_r       <= 1'b0;
      mw_v_r       <= 1'b0;
      pc_r         <= '0;
      halt_r       <= 1'b0;
      plen_r       <= '0;
      tick_r       <= '0;
      ret_r        <= '0;
      hz_r         <= 1'b0;
      ld_pend_r    <= 1'b0;
      fetch_pend_r <= 1'b0;
      clr_addr_r   <= '0;
    end else begin
      if (cfg_we) begin
        plen_r <= cfg_wdata;
      end

      // clearing pass over data memory
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end

      // new item: clear the per-item report
      if (cmd.accept) begin
        r_wbv_r    <= 1'b0;
        r_wbreg_r  <= '0;
        r_wbval_r  <= '0;
        r_stv_r    <= 1'b0;
        r_staddr_r <= '0;
        r_stval_r  <= '0;
        r_stall_r  <= 1'b0;
        r_flush_r  <= 1'b0;
      end

      // write-back, memory and hazard check
      if (cmd.mem) begin
        tick_r <= (tick_r == '1) ? tick_r : tick_r + 32'd1;
        if (mw_v_r) begin
          if (mw_wr_ok) begin
            rf_v_r[mw_r.dest[RADDR_W-1:0]] <= 1'b1;
            r_wbv_r   <= 1'b1;
            r_wbreg_r <= mw_r.dest[4:0];
            r_wbval_r <= mw_r.wbv;
            ret_r     <= (ret_r == '1) ? ret_r : ret_r + 32'd1;
          end else if (mw_r.ins.op inside {OP_SW, OP_HALT, [OP_BEQ:OP_J]}) begin
            ret_r <= (ret_r == '1) ? ret_r : ret_r + 32'd1;
          end
        end
        mw_v_r <= em_v_r;
        if (em_v_r) begin
          mw_r      <= em_r;
          ld_pend_r <= em_r.mrd && em_inrange;
          if (em_r.mrd) begin
            mw_r.wbv <= 32'd0;
          end else if (!em_r.mwr) begin
            mw_r.wbv <= em_r.res;
          end
          if (em_r.mwr && em_inrange) begin
            r_stv_r    <= 1'b1;
            r_staddr_r <= em_r.res[ST_ADDR_W-1:0];
            r_stval_r  <= em_r.sdata;
          end
        end
        em_v_r <= 1'b0;
        hz_r   <= fd_v_r && de_v_r && de_r.mrd && !de_r.dest[5] && (de_r.dest != 6'd0) &&
                  (fd_r.ins.rs1 == de_r.dest || fd_r.ins.rs2 == de_r.dest);
      end

      // load data and register reads
      if (cmd.rd) begin
        if (ld_pend_r) begin
          mw_r.wbv <= dmem_q_r;
        end
        ld_pend_r <= 1'b0;
        rfa_v_r   <= rf_v_r[de_r.ins.rs1[RADDR_W-1:0]];
        rfb_v_r   <= rf_v_r[rd_b_reg[RADDR_W-1:0]];
      end

      // execute
      if (cmd.ex && de_v_r) begin
        em_r   <= em_nxt;
        em_v_r <= 1'b1;
        de_v_r <= 1'b0;
        if (em_nxt.taken) begin
          pc_r <= PC_W'(de_r.ins.tgt);
        end
        if (de_r.ins.op == OP_HALT) begin
          halt_r <= 1'b1;
        end
      end

      // divide result
      if (cmd.div_end) begin
        em_r.res <= div_q;
      end

      // decode or stall, flush, fetch request
      if (cmd.dec) begin
        if (hz_r) begin
          r_stall_r <= 1'b1;
        end else if (fd_v_r) begin
          de_r   <= de_nxt;
          de_v_r <= 1'b1;
          fd_v_r <= 1'b0;
        end
        if (em_v_r && em_r.taken) begin
          fd_v_r    <= 1'b0;
          de_v_r    <= 1'b0;
          r_flush_r <= 1'b1;
        end
        if (fetch_ok) begin
          if (32'(pc_r) >= len32) begin
            halt_r <= 1'b1;
          end else begin
            fetch_pend_r <= 1'b1;
            pc_r         <= pc_r + 1'b1;
          end
        end
      end

      // fetch completes
      if (cmd.fetch && fetch_pend_r) begin
        fd_r         <= '0;
        fd_r.ins     <= imem_q_r;
        fd_v_r       <= 1'b1;
        fetch_pend_r <= 1'b0;
      end

      // result register
      if (cmd.out_load) begin
        out_tdata_r <= {3'b000, ret_r, tick_r, drained, halt_r, r_flush_r, r_stall_r,
                        r_stval_r, r_staddr_r, r_stv_r, r_wbval_r, r_wbreg_r, r_wbv_r};
      end
    end
  end

  assign sts.clr_last = (clr_addr_r == '1);
  assign sts.ex_div   = de_v_r && (de_r.ins.op == OP_DIV);
  assign sts.div_done = div_done;
  assign out_tdata    = out_tdata_r;

endmodule

`default_nettype wire

/* src/fsp_ctrl.sv */
// ----------------------------------------------------------------------------
// fsp_ctrl
// Controller state machine: clearing pass, item acceptance, the phases of
// one pipeline tick and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_ctrl
  import fsp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire cmd_t     in_cmd,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output ctl_cmd_t      cmd,
  input  wire ctl_sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_v_r, out_v_nxt;

  // state and result valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    out_v_nxt = out_v_r && !out_tready;
    case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_cmd == CMD_TICK) ? ST_MEM : ST_DONE;
        end
      end
      ST_MEM: begin
        cmd.mem   = 1'b1;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EX;
      end
      ST_EX: begin
        cmd.ex    = 1'b1;
        state_nxt = sts.ex_div ? ST_DIV : ST_DEC;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.div_end = 1'b1;
          state_nxt   = ST_DEC;
        end
      end
      ST_DEC: begin
        cmd.dec   = 1'b1;
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_v_r || out_tready) begin
          cmd.out_load = 1'b1;
          out_v_nxt    = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_v_r;

endmodule

`default_nettype wire
